@@ design/assert_macros.svh @@
// assertion macros used by the checker smx_chk
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/smx_pkg.sv @@
// shared types, constants and functions of the top-k classifier
// no dependencies
package smx_pkg;

    localparam int MAX_CLASSES_DEF = 1024;
    localparam int MAX_TOP_K_DEF   = 16;

    localparam int SCORE_W   = 16;
    localparam int CONF_W    = 17;
    localparam int IDX_OUT_W = 10;
    localparam int TOPK_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = 26;
    localparam int EXP_SPAN  = 4096;
    localparam int EXP_AW    = 12;
    localparam int NUM_W     = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_K   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFTMAX = 1'd1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // exp(-1/256) in Q0.31 from the alternating series in Q0.62
    function automatic logic [30:0] exp_ratio();
        logic [63:0] term;
        logic [63:0] acc;
        term = 64'd1 << 62;
        acc  = term;
        for (int n = 1; n <= 8; n++) begin
            term = term / 64'(256 * n);
            if ((n & 1) == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return 31'((acc + (64'd1 << 30)) >> 31);
    endfunction

    localparam logic [30:0] EXP_R = exp_ratio();

    typedef enum logic [6:0] {
        S_FILL = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_PICK = 7'b0001000,
        S_DST  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_PRES = 7'b1000000
    } t_state;

    typedef struct packed {
        logic fill;
        logic in_ready;
        logic sum_run;
        logic out_rd;
        logic div_start;
        logic res_load;
        logic out_valid;
        logic next_k;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic fill_done;
        logic acc_last;
        logic softmax;
        logic sum_done;
        logic out_none;
        logic div_done;
        logic out_taken;
    } t_sts;

endpackage

@@ design/smx_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on smx_pkg
module smx_div #(
    parameter int NUM_W = smx_pkg::NUM_W,
    parameter int DEN_W = smx_pkg::SUM_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   trial;
    logic             qbit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[NUM_W-1]};
        qbit   = (trial >= {1'b0, r_den});
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = qbit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], qbit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

@@ design/smx_ctrl.sv @@
// controller state machine of the top-k classifier
// depends on smx_pkg
module smx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  smx_pkg::t_sts i_sts,
    output smx_pkg::t_cmd o_cmd
);
    smx_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            smx_pkg::S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_done) n_state = smx_pkg::S_LOAD;
            end
            smx_pkg::S_LOAD: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.acc_last) begin
                    n_state = i_sts.softmax ? smx_pkg::S_SUM : smx_pkg::S_PICK;
                end
            end
            smx_pkg::S_SUM: begin
                o_cmd.sum_run = 1'b1;
                if (i_sts.sum_done) n_state = smx_pkg::S_PICK;
            end
            smx_pkg::S_PICK: begin
                if (i_sts.out_none) begin
                    o_cmd.clear = 1'b1;
                    n_state     = smx_pkg::S_LOAD;
                end else if (i_sts.softmax) begin
                    o_cmd.out_rd = 1'b1;
                    n_state      = smx_pkg::S_DST;
                end else begin
                    o_cmd.res_load = 1'b1;
                    n_state        = smx_pkg::S_PRES;
                end
            end
            smx_pkg::S_DST: begin
                o_cmd.div_start = 1'b1;
                n_state         = smx_pkg::S_DIV;
            end
            smx_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = smx_pkg::S_PRES;
                end
            end
            smx_pkg::S_PRES: begin
                o_cmd.out_valid = 1'b1;
                if (i_sts.out_taken) begin
                    o_cmd.next_k = 1'b1;
                    n_state      = smx_pkg::S_PICK;
                end
            end
            default: n_state = smx_pkg::S_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smx_pkg::S_FILL;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ design/smx_dp.sv @@
// datapath: score store, exp table, top-k list, sum pass, result register
// depends on smx_pkg and smx_div
module smx_dp #(
    parameter int MAX_CLASSES = smx_pkg::MAX_CLASSES_DEF,
    parameter int MAX_TOP_K   = smx_pkg::MAX_TOP_K_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  smx_pkg::t_cmd                        i_cmd,
    output smx_pkg::t_sts                        o_sts,
    input  logic                                 i_cfg_we,
    input  logic [smx_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [smx_pkg::TOPK_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic signed [smx_pkg::SCORE_W-1:0]   i_score,
    input  logic                                 i_last_class,
    input  logic                                 i_out_ready,
    output logic                                 o_in_ready,
    output logic                                 o_out_valid,
    output logic [smx_pkg::IDX_OUT_W-1:0]        o_class_index,
    output logic signed [smx_pkg::CONF_W-1:0]    o_confidence,
    output logic                                 o_last_result
);
    localparam int SW   = smx_pkg::SCORE_W;
    localparam int AW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNTW = $clog2(MAX_CLASSES + 1);
    localparam int KI   = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
    localparam int KW   = $clog2(MAX_TOP_K + 1);
    localparam int NW   = (KW > smx_pkg::TOPK_W) ? KW : smx_pkg::TOPK_W;
    localparam int EAW  = smx_pkg::EXP_AW;
    localparam int SUMW = smx_pkg::SUM_W;

    localparam logic [1:0] FPH_LO  = 2'd0;
    localparam logic [1:0] FPH_HI  = 2'd1;
    localparam logic [1:0] FPH_UPD = 2'd2;

    function automatic logic [EAW-1:0] exp_addr(input logic signed [SW-1:0] mx,
                                                  input logic signed [SW-1:0] s);
        logic signed [SW:0] diff;
        diff = {mx[SW-1], mx} - {s[SW-1], s};
        if (diff > (SW+1)'(smx_pkg::EXP_SPAN - 1)) begin
            return {EAW{1'b1}};
        end
        return diff[EAW-1:0];
    endfunction

    // configuration
    logic [smx_pkg::TOPK_W-1:0] r_top_k;
    logic                       r_softmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_k   <= smx_pkg::TOPK_W'(1);
            r_softmax <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smx_pkg::CFG_TOP_K:   r_top_k   <= i_cfg_data;
                smx_pkg::CFG_SOFTMAX: r_softmax <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // exp table build
    logic [15:0]     r_exp [smx_pkg::EXP_SPAN];
    logic [1:0]      r_fph;
    logic [EAW-1:0]  r_faddr;
    logic [32:0]     r_a;
    logic [46:0]     r_plo;
    logic [47:0]     r_phi;
    logic [63:0]     prod;
    logic [33:0]     a_rnd;
    logic [15:0]     e_val;

    always_comb begin
        prod  = {r_phi, 16'd0} + 64'(r_plo) + (64'd1 << 30);
        a_rnd = {1'b0, r_a} + 34'd32768;
        e_val = (a_rnd[33:16] > 18'd65535) ? 16'hFFFF : a_rnd[31:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fph   <= FPH_LO;
            r_faddr <= '0;
            r_a     <= 33'd1 << 32;
        end else if (i_cmd.fill) begin
            case (r_fph)
                FPH_LO:  r_fph <= FPH_HI;
                FPH_HI:  r_fph <= FPH_UPD;
                FPH_UPD: begin
                    r_fph   <= FPH_LO;
                    r_faddr <= r_faddr + 1'b1;
                    r_a     <= prod[63:31];
                end
                default: r_fph <= FPH_LO;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_plo <= r_a[15:0] * smx_pkg::EXP_R;
        r_phi <= r_a[32:16] * smx_pkg::EXP_R;
        if (i_cmd.fill && r_fph == FPH_LO) begin
            r_exp[r_faddr] <= e_val;
        end
    end

    // loading
    logic                  accept;
    logic                  room;
    logic [CNTW-1:0]       r_count;
    logic signed [SW-1:0]  r_max;
    logic [SW-1:0]         r_store [MAX_CLASSES];

    assign accept = i_in_valid && i_cmd.in_ready;
    assign room   = (r_count < CNTW'(MAX_CLASSES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= {1'b1, {(SW-1){1'b0}}};
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_max   <= {1'b1, {(SW-1){1'b0}}};
        end else if (accept && room) begin
            r_count <= r_count + 1'b1;
            if (i_score > r_max) r_max <= i_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            r_store[r_count[AW-1:0]] <= i_score;
        end
    end

    // sorted top-k list
    logic signed [SW-1:0] r_bsc [MAX_TOP_K];
    logic [AW-1:0]        r_bix [MAX_TOP_K];
    logic [MAX_TOP_K-1:0] r_bv;
    logic [KW-1:0]        r_bcnt;
    logic signed [SW-1:0] n_bsc [MAX_TOP_K];
    logic [AW-1:0]        n_bix [MAX_TOP_K];
    logic [MAX_TOP_K-1:0] n_bv;
    logic signed [SW-1:0] sh_sc [MAX_TOP_K];
    logic [AW-1:0]        sh_ix [MAX_TOP_K];
    logic [MAX_TOP_K-1:0] sh_v;
    logic [MAX_TOP_K-1:0] lt;
    logic [MAX_TOP_K-1:0] lt_prev;

    always_comb begin
        for (int j = 0; j < MAX_TOP_K; j++) begin
            lt[j] = !r_bv[j] || (r_bsc[j] < i_score);
        end
        lt_prev  = lt << 1;
        sh_sc[0] = r_bsc[0];
        sh_ix[0] = r_bix[0];
        sh_v[0]  = r_bv[0];
        for (int j = 1; j < MAX_TOP_K; j++) begin
            sh_sc[j] = r_bsc[j-1];
            sh_ix[j] = r_bix[j-1];
            sh_v[j]  = r_bv[j-1];
        end
        for (int j = 0; j < MAX_TOP_K; j++) begin
            if (lt[j] && !lt_prev[j]) begin
                n_bsc[j] = i_score;
                n_bix[j] = r_count[AW-1:0];
                n_bv[j]  = 1'b1;
            end else if (lt[j]) begin
                n_bsc[j] = sh_sc[j];
                n_bix[j] = sh_ix[j];
                n_bv[j]  = sh_v[j];
            end else begin
                n_bsc[j] = r_bsc[j];
                n_bix[j] = r_bix[j];
                n_bv[j]  = r_bv[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv   <= '0;
            r_bcnt <= '0;
        end else if (i_cmd.clear) begin
            r_bv   <= '0;
            r_bcnt <= '0;
        end else if (accept && room) begin
            r_bv <= n_bv;
            if (r_bcnt < KW'(MAX_TOP_K)) r_bcnt <= r_bcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            r_bsc <= n_bsc;
            r_bix <= n_bix;
        end
    end

    // sum pass
    logic [CNTW-1:0]      r_ridx;
    logic                 r_v1, r_v2;
    logic [SW-1:0]        r_st_q;
    logic [15:0]          r_tab_q;
    logic [SUMW-1:0]      r_sum;
    logic [SUMW:0]        sum_nx;
    logic                 issue;
    logic                 acc_last;
    logic [KW-1:0]        r_k;
    logic [EAW-1:0]       tab_addr;

    assign acc_last = accept && i_last_class;
    assign issue    = i_cmd.sum_run && (r_ridx < r_count);
    assign sum_nx   = {1'b0, r_sum} + (SUMW+1)'(r_tab_q);
    assign tab_addr = r_v1 ? exp_addr(r_max, r_st_q) : exp_addr(r_max, r_bsc[r_k[KI-1:0]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ridx <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_sum  <= '0;
        end else if (acc_last) begin
            r_ridx <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_sum  <= '0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (issue) r_ridx <= r_ridx + 1'b1;
            if (r_v2) r_sum <= (sum_nx > {1'b0, smx_pkg::SUM_MAX}) ? smx_pkg::SUM_MAX
                                                                   : sum_nx[SUMW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) r_st_q <= r_store[r_ridx[AW-1:0]];
        if (r_v1 || i_cmd.out_rd) r_tab_q <= r_exp[tab_addr];
    end

    // result selection
    logic [NW-1:0] tk_w, m1, m2;
    logic [KW-1:0] n_res;

    always_comb begin
        tk_w  = (r_top_k == '0) ? NW'(1) : NW'(r_top_k);
        m1    = (tk_w > NW'(MAX_TOP_K)) ? NW'(MAX_TOP_K) : tk_w;
        m2    = (m1 > NW'(r_bcnt)) ? NW'(r_bcnt) : m1;
        n_res = KW'(m2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (acc_last) begin
            r_k <= '0;
        end else if (i_cmd.next_k) begin
            r_k <= r_k + 1'b1;
        end
    end

    logic                       div_done;
    logic [smx_pkg::NUM_W-1:0]  quot;
    logic [smx_pkg::NUM_W-1:0]  numer;
    logic [15:0]                prob;

    assign numer = {1'b0, r_tab_q, 16'd0} + smx_pkg::NUM_W'(r_sum >> 1);

    smx_div #(
        .NUM_W (smx_pkg::NUM_W),
        .DEN_W (SUMW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (numer),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        if (r_sum == '0) begin
            prob = 16'd0;
        end else if (quot > smx_pkg::NUM_W'(16'hFFFF)) begin
            prob = 16'hFFFF;
        end else begin
            prob = quot[15:0];
        end
    end

    logic [smx_pkg::IDX_OUT_W-1:0]     r_res_idx;
    logic signed [smx_pkg::CONF_W-1:0] r_res_conf;
    logic                              r_res_last;
    logic signed [SW-1:0]              sel_sc;

    assign sel_sc = r_bsc[r_k[KI-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_idx  <= smx_pkg::IDX_OUT_W'(r_bix[r_k[KI-1:0]]);
            r_res_conf <= r_softmax ? {1'b0, prob} : {sel_sc[SW-1], sel_sc};
            r_res_last <= ((r_k + 1'b1) == n_res);
        end
    end

    assign o_in_ready    = i_cmd.in_ready;
    assign o_out_valid   = i_cmd.out_valid;
    assign o_class_index = r_res_idx;
    assign o_confidence  = r_res_conf;
    assign o_last_result = r_res_last;

    always_comb begin
        o_sts.fill_done = i_cmd.fill && (r_fph == FPH_UPD) && (r_faddr == {EAW{1'b1}});
        o_sts.acc_last  = acc_last;
        o_sts.softmax   = r_softmax;
        o_sts.sum_done  = (r_ridx == r_count) && !r_v1 && !r_v2;
        o_sts.out_none  = (r_k >= n_res);
        o_sts.div_done  = div_done;
        o_sts.out_taken = i_cmd.out_valid && i_out_ready;
    end
endmodule

@@ design/softmax_top_k_classifier.sv @@
// top level of the softmax top-k classifier
// depends on smx_pkg, smx_ctrl, smx_dp
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready | i_score, i_last_class
//  out     | output    | o_out_valid/i_out_ready | o_class_index, o_confidence, o_last_result
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// scores load at one word per cycle while o_in_ready is high; the last word ends the vector
// softmax on: a sum pass over the stored scores, then one divider run per result
// softmax off: no divider run; results wait in the output register for i_out_ready
// after reset the exp table of 4096 entries is built; no word is taken meanwhile
// reset is synchronous, active low; no input is taken while results are sent
module softmax_top_k_classifier #(
    parameter int MAX_CLASSES = smx_pkg::MAX_CLASSES_DEF,
    parameter int MAX_TOP_K   = smx_pkg::MAX_TOP_K_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [smx_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smx_pkg::TOPK_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [smx_pkg::SCORE_W-1:0] i_score,
    input  logic                               i_last_class,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [smx_pkg::IDX_OUT_W-1:0]      o_class_index,
    output logic signed [smx_pkg::CONF_W-1:0]  o_confidence,
    output logic                               o_last_result
);
    smx_pkg::t_cmd cmd;
    smx_pkg::t_sts sts;

    smx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    smx_dp #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_TOP_K   (MAX_TOP_K)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_score       (i_score),
        .i_last_class  (i_last_class),
        .i_out_ready   (i_out_ready),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_class_index (o_class_index),
        .o_confidence  (o_confidence),
        .o_last_result (o_last_result)
    );
endmodule

@@ design/smx_chk.sv @@
// port-level checker of the top-k classifier, bound to the top level
// depends on smx_pkg and assert_macros.svh
`include "assert_macros.svh"
module smx_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_last_class,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [smx_pkg::IDX_OUT_W-1:0]      o_class_index,
    input logic signed [smx_pkg::CONF_W-1:0]  o_confidence,
    input logic                               o_last_result
);
    // results hold while stalled
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_class_index) && $stable(o_confidence) && $stable(o_last_result), "result changed while stalled")
    // no input taken while a result is offered
    `CHK_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "input ready during result")
    // last word closes the input side
    `CHK_NEXT(a_last_stops, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last_class, !o_in_ready, "ready after last word")
    // a mid-vector word keeps the input side open
    `CHK_NEXT(a_load_open, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_last_class, o_in_ready, "ready dropped mid vector")
endmodule

bind softmax_top_k_classifier smx_chk u_chk (.*);

@@ tb/testbench.sv @@
// testbench for softmax_top_k_classifier: random and directed score vectors
// a scoreboard class predicts ranked results from the scores and checks each output word
// depends on smx_pkg and the classifier rtl
module testbench;
    import smx_pkg::*;

    typedef struct {
        logic [IDX_OUT_W-1:0] idx;
        logic [CONF_W-1:0]    conf;
        logic                 last;
    } ranked_t;

    class topk_scoreboard;
        int unsigned exp_tab[EXP_SPAN];
        int          scores[1024];
        int          count;
        int          peak;
        int          best_idx[16];
        int          best_sc[16];
        int          n_best;
        int          top_k;
        bit          use_softmax;
        ranked_t     pending_q[$];
        int          errors;

        function new();
            longint unsigned term, acc, r, a, e;
            term = 64'd1 << 62;
            acc = term;
            for (int n = 1; n <= 8; n++) begin
                term = term / (256 * n);
                if (n % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
            r = (acc + (64'd1 << 30)) >> 31;
            a = 64'd1 << 32;
            for (int d = 0; d < EXP_SPAN; d++) begin
                e = (a + 32768) >> 16;
                exp_tab[d] = (e > 65535) ? 65535 : int'(e);
                a = (a * r + (64'd1 << 30)) >> 31;
            end
            top_k = 1;
            use_softmax = 1;
            errors = 0;
            clear_vector();
        endfunction

        function void clear_vector();
            count = 0;
            peak = -32768;
            n_best = 0;
            for (int i = 0; i < 16; i++) begin
                best_idx[i] = 0;
                best_sc[i] = -32768;
            end
        endfunction

        function int unsigned exp_of(int s);
            int d;
            d = peak - s;
            if (d < 0) d = 0;
            if (d > EXP_SPAN - 1) d = EXP_SPAN - 1;
            return exp_tab[d];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, int value);
            if (index == CFG_TOP_K) top_k = value & 31;
            else use_softmax = 1'(value & 1);
        endfunction

        function void note(logic signed [15:0] score, logic last);
            int s, pos, j, n;
            longint unsigned sum, conf;
            ranked_t r;
            s = score;
            if (count < 1024) begin
                scores[count] = s;
                if (s > peak) peak = s;
                pos = n_best;
                while (pos > 0 && best_sc[pos-1] < s) pos--;
                if (pos < 16) begin
                    j = (n_best < 16) ? n_best : 15;
                    while (j > pos) begin
                        best_sc[j] = best_sc[j-1];
                        best_idx[j] = best_idx[j-1];
                        j--;
                    end
                    best_sc[pos] = s;
                    best_idx[pos] = count;
                    if (n_best < 16) n_best++;
                end
                count++;
            end
            if (!last) return;
            n = (top_k == 0) ? 1 : top_k;
            if (n > 16) n = 16;
            if (n > n_best) n = n_best;
            sum = 0;
            if (use_softmax) begin
                for (int i = 0; i < count; i++) begin
                    sum += exp_of(scores[i]);
                    if (sum > 67108863) sum = 67108863;
                end
            end
            for (int k = 0; k < n; k++) begin
                if (use_softmax) begin
                    if (sum == 0) conf = 0;
                    else begin
                        conf = (longint'(exp_of(best_sc[k])) * 65536 + sum / 2) / sum;
                        if (conf > 65535) conf = 65535;
                    end
                    r.conf = conf[CONF_W-1:0];
                end else begin
                    r.conf = CONF_W'(best_sc[k]);
                end
                r.idx = best_idx[k][IDX_OUT_W-1:0];
                r.last = (k + 1 == n);
                pending_q = {pending_q, r};
            end
            clear_vector();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(logic [IDX_OUT_W-1:0] idx, logic [CONF_W-1:0] conf, logic last);
            ranked_t r;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected word idx=%0d conf=%h", idx, conf));
                return;
            end
            r = pending_q.pop_front();
            if (idx !== r.idx) report($sformatf("class_index %0d, want %0d", idx, r.idx));
            if (conf !== r.conf) report($sformatf("confidence %h, want %h", conf, r.conf));
            if (last !== r.last) report($sformatf("last_result %b, want %b", last, r.last));
        endtask
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TOP_K;
    logic [TOPK_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 0;
    logic                 o_in_ready;
    logic signed [15:0]   i_score = '0;
    logic                 i_last_class = 0;
    logic                 o_out_valid;
    logic                 i_out_ready = 0;
    logic [IDX_OUT_W-1:0] o_class_index;
    logic signed [CONF_W-1:0] o_confidence;
    logic                 o_last_result;

    topk_scoreboard ranking = new();
    bit calm = 0;
    bit hold_tog = 0;
    bit hold_seen = 0;
    int hold_cycles = 0;

    softmax_top_k_classifier u_dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) ranking.note(i_score, i_last_class);
        if (i_rst_n && o_out_valid && i_out_ready)
            ranking.check(o_class_index, o_confidence, o_last_result);
    end

    // receiver stall pattern, long hold on request
    always @(negedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_cycles <= 1500;
            i_out_ready <= 0;
        end else if (hold_cycles > 0) begin
            i_out_ready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 17);
        end
    end

    // entered and left just after a rising edge; valid stays up for the next word
    task automatic send_word(logic signed [15:0] s, logic last);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 17) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_in_valid = 1;
        i_score = s;
        i_last_class = last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 0;
        while (ranking.pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, int value);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_index = index;
        i_cfg_data = value[TOPK_W-1:0];
        ranking.write_reg(index, value);
        @(negedge i_clk);
        i_cfg_we = 0;
        @(posedge i_clk);
    endtask

    task automatic random_vector(int len, bit wide);
        int base;
        base = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < len; i++) begin
            if (wide || base > 32000) send_word(16'($urandom_range(0, 65535)), i == len - 1);
            else send_word(16'(base + $urandom_range(0, 700)), i == len - 1);
        end
    endtask

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(posedge i_clk);

        // extremes and ties
        write_reg(CFG_TOP_K, 16);
        write_reg(CFG_SOFTMAX, 1);
        send_word(16'sh7fff, 0);
        send_word(-16'sh8000, 0);
        send_word(16'sh0000, 0);
        send_word(16'sh0100, 0);
        send_word(16'sh0100, 0);
        send_word(16'sh7fff, 0);
        send_word(-16'sh0001, 1);
        send_word(16'sh1234, 1);
        drain();
        write_reg(CFG_SOFTMAX, 0);
        write_reg(CFG_TOP_K, 0);
        send_word(-16'sh8000, 0);
        send_word(16'sh5555, 1);
        drain();
        write_reg(CFG_TOP_K, 31);
        random_vector(20, 1);
        drain();

        // long receiver hold while the sender keeps offering
        write_reg(CFG_SOFTMAX, 1);
        write_reg(CFG_TOP_K, 5);
        calm = 1;
        random_vector(30, 0);
        hold_tog = ~hold_tog;
        random_vector(8, 1);
        random_vector(6, 0);
        calm = 0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            write_reg(CFG_TOP_K, $urandom_range(0, 31));
            write_reg(CFG_SOFTMAX, phase % 2);
            calm = (phase == 3);
            for (int v = 0; v < 4; v++) begin
                int len;
                len = $urandom_range(1, 10);
                random_vector(len, $urandom_range(0, 2) == 0);
            end
            drain();
        end
        if (ranking.pending_q.size() != 0) ranking.report("results left over");
        if (ranking.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
